### sv/kmcu_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and stream layouts for the k-way merge union.
// No dependencies; imported by kway_merge_count_union.
package kmcu_pkg;

    localparam int NUM_SOURCES = 8;
    localparam int SRC_W       = 3;
    localparam int WORD_W      = 64;
    localparam int COUNT_W     = 32;
    localparam int TOTAL_W     = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // input tdata: source, word, count, zero pad to whole bytes
    localparam int IN_BITS     = SRC_W + WORD_W + COUNT_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // output tdata: kept, merged_word, summed_count, refill_mask, words_kept, total_kept
    localparam int OUT_BITS    = 1 + WORD_W + COUNT_W + NUM_SOURCES + TOTAL_W + TOTAL_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [WORD_W-1:0]  WORD_MAX  = 64'hffff_ffff_ffff_ffff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF      = 1'b0,
        CFG_ACTIVE_MASK = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [SRC_W-1:0]   source;
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] count;
        logic               end_of_list;
    } t_in_item;

endpackage

### sv/kway_merge_count_union.sv
`timescale 1ns / 1ps
// K-way merge union with saturating count sum over up to eight ascending sources.
// Depends on kmcu_pkg for widths, stream layouts and register indexes.
//
//  channel   | signals                                   | moves
//  ----------+-------------------------------------------+------------------------------
//  s_axis    | tvalid tready tdata tlast                 | head refill or end request
//  m_axis    | tvalid tready tdata tuser                 | round or final result
//  cfg       | i_cfg_we i_cfg_index i_cfg_data           | register write, no read-back
//
// One request per cycle while the result register is empty or being taken: a
// request is held in the input register, then the head update, the 8-way
// minimum tree, the count adder tree and the totals update run in one pass into
// the result register, where the result becomes visible. An empty input
// register still fills while a result waits; it holds only while the result
// register is full and not being taken. Reset (synchronous, active low) clears
// control state, heads become invalid and the totals zero.
module kway_merge_count_union
    import kmcu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [2:0] source, [66:3] word, [98:67] count, [103:99] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tlast,   // end_of_list

    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [0] kept, [64:1] merged_word, [96:65] summed_count, [104:97] refill_mask,
    // [168:105] words_kept, [232:169] total_kept, [239:233] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tuser,   // final_res

    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // configuration
    logic [COUNT_W-1:0]     r_cutoff;
    logic [NUM_SOURCES-1:0] r_active;

    // input register
    logic                   r_in_valid;
    t_in_item               r_in;

    // merge state
    logic [WORD_W-1:0]      r_head_word  [NUM_SOURCES];
    logic [COUNT_W-1:0]     r_head_count [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] r_head_valid;
    logic [NUM_SOURCES-1:0] r_ended;
    logic [TOTAL_W-1:0]     r_words_kept;
    logic [TOTAL_W-1:0]     r_total_kept;

    // result register
    logic                   r_out_valid;
    logic                   r_out_final;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                   out_free;
    logic                   fire;
    logic                   upd;
    logic [NUM_SOURCES-1:0] src_bit;
    logic [NUM_SOURCES-1:0] n_ended;
    logic [NUM_SOURCES-1:0] valid_pre;
    logic [NUM_SOURCES-1:0] live_before;
    logic [NUM_SOURCES-1:0] live;
    logic                   round;
    logic                   fin;
    logic [WORD_W-1:0]      eff_word  [NUM_SOURCES];
    logic [COUNT_W-1:0]     eff_count [NUM_SOURCES];
    logic [WORD_W-1:0]      min_l1 [NUM_SOURCES/2];
    logic [WORD_W-1:0]      min_l2 [NUM_SOURCES/4];
    logic [WORD_W-1:0]      min_word;
    logic [NUM_SOURCES-1:0] refill;
    logic [COUNT_W:0]       sum_l1 [NUM_SOURCES/2];
    logic [COUNT_W+1:0]     sum_l2 [NUM_SOURCES/4];
    logic [COUNT_W+2:0]     sum_all;
    logic [COUNT_W-1:0]     sum_sat;
    logic                   kept;
    logic [TOTAL_W-1:0]     n_words_kept;
    logic [TOTAL_W-1:0]     n_total_kept;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_final;

    always_comb begin
        src_bit = '0;
        src_bit[r_in.source] = 1'b1;
        upd     = r_in_valid && r_active[r_in.source] && !r_ended[r_in.source];

        n_ended   = r_ended;
        valid_pre = r_head_valid;
        if (upd) begin
            if (r_in.end_of_list) begin
                n_ended   = r_ended | src_bit;
                valid_pre = r_head_valid & ~src_bit;
            end else begin
                valid_pre = r_head_valid | src_bit;
            end
        end

        live_before = r_active & ~r_ended;
        live        = r_active & ~n_ended;
        fin         = r_in_valid && (live == '0) && (live_before != '0);
        round       = r_in_valid && (live != '0) && ((live & ~valid_pre) == '0);

        // heads as they stand after this request's refill
        for (int s = 0; s < NUM_SOURCES; s++) begin
            if (upd && !r_in.end_of_list && src_bit[s]) begin
                eff_word[s]  = r_in.word;
                eff_count[s] = r_in.count;
            end else begin
                eff_word[s]  = r_head_word[s];
                eff_count[s] = r_head_count[s];
            end
        end

        // minimum tree; sources not live read as the largest word
        for (int i = 0; i < NUM_SOURCES/2; i++) begin
            logic [WORD_W-1:0] a;
            logic [WORD_W-1:0] b;
            a = live[2*i]   ? eff_word[2*i]   : WORD_MAX;
            b = live[2*i+1] ? eff_word[2*i+1] : WORD_MAX;
            min_l1[i] = (b < a) ? b : a;
        end
        for (int i = 0; i < NUM_SOURCES/4; i++) begin
            min_l2[i] = (min_l1[2*i+1] < min_l1[2*i]) ? min_l1[2*i+1] : min_l1[2*i];
        end
        min_word = (min_l2[1] < min_l2[0]) ? min_l2[1] : min_l2[0];

        for (int s = 0; s < NUM_SOURCES; s++) begin
            refill[s] = live[s] && (eff_word[s] == min_word);
        end

        // full-width adder tree, saturate once at the end
        for (int i = 0; i < NUM_SOURCES/2; i++) begin
            sum_l1[i] = (refill[2*i]   ? {1'b0, eff_count[2*i]}   : '0)
                      + (refill[2*i+1] ? {1'b0, eff_count[2*i+1]} : '0);
        end
        for (int i = 0; i < NUM_SOURCES/4; i++) begin
            sum_l2[i] = {1'b0, sum_l1[2*i]} + {1'b0, sum_l1[2*i+1]};
        end
        sum_all = {1'b0, sum_l2[0]} + {1'b0, sum_l2[1]};
        sum_sat = (sum_all[COUNT_W+2:COUNT_W] != '0) ? COUNT_MAX : sum_all[COUNT_W-1:0];

        kept         = sum_sat >= r_cutoff;
        n_words_kept = r_words_kept;
        n_total_kept = r_total_kept;
        if (round && kept) begin
            n_words_kept = r_words_kept + TOTAL_W'(1);
            n_total_kept = r_total_kept + TOTAL_W'(sum_sat);
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= '0;
            r_active <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CUTOFF:      r_cutoff <= i_cfg_data[COUNT_W-1:0];
                CFG_ACTIVE_MASK: r_active <= i_cfg_data[NUM_SOURCES-1:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.source      <= i_s_axis_tdata[SRC_W-1:0];
            r_in.word        <= i_s_axis_tdata[SRC_W +: WORD_W];
            r_in.count       <= i_s_axis_tdata[SRC_W+WORD_W +: COUNT_W];
            r_in.end_of_list <= i_s_axis_tlast;
        end
    end

    // head store: written at the refilled source only
    always_ff @(posedge i_clk) begin
        if (fire && upd && !r_in.end_of_list) begin
            r_head_word[r_in.source]  <= r_in.word;
            r_head_count[r_in.source] <= r_in.count;
        end
    end

    // merge control state and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= '0;
            r_ended      <= '0;
            r_words_kept <= '0;
            r_total_kept <= '0;
        end else if (fire) begin
            r_ended      <= n_ended;
            r_head_valid <= round ? (valid_pre & ~refill) : valid_pre;
            r_words_kept <= n_words_kept;
            r_total_kept <= n_total_kept;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && (round || fin)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && (round || fin)) begin
            r_out_final <= fin;
            if (fin) begin
                r_out_data <= OUT_TDATA_W'({r_total_kept, r_words_kept,
                                            {(1 + WORD_W + COUNT_W + NUM_SOURCES){1'b0}}});
            end else begin
                r_out_data <= OUT_TDATA_W'({n_total_kept, n_words_kept, refill,
                                            sum_sat, min_word, kept});
            end
        end
    end

endmodule
